// ===== rtl/pss_pkg.sv =====
// ----------------------------------------------------------------------------
// pss_pkg
// Types and constants shared by the priority scheduler select block.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int SLOT_W = 6;
    localparam int PRIO_W = 7;
    localparam int TICK_W = 32;
    localparam int SUM_W  = TICK_W + 1;
    localparam int NUM_W  = TICK_W + 4;
    localparam int Q_W    = 4;
    localparam int DIV_STEPS = Q_W;
    localparam int STEP_W = $clog2(DIV_STEPS);

    localparam logic [PRIO_W-1:0] PRIO_MAX  = 7'd100;
    localparam logic [PRIO_W:0]   PRIO_BIAS = 8'd5;
    localparam logic [Q_W-1:0]    NICE_IDLE = 4'd5;

    typedef struct packed {
        logic [SLOT_W-1:0] entry_index;
        logic              runnable;
        logic [PRIO_W-1:0] static_priority;
        logic [TICK_W-1:0] run_ticks;
        logic [TICK_W-1:0] sleep_ticks;
        logic [TICK_W-1:0] run_count;
        logic [TICK_W-1:0] start_tick;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] winner_index;
        logic [PRIO_W-1:0] winner_priority;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic update;
        logic emit;
    } pss_cmd_t;

    typedef struct packed {
        logic last;
    } pss_status_t;

endpackage

// ===== rtl/pss_if.sv =====
// ----------------------------------------------------------------------------
// pss_if
// Valid/ready channels carrying requests into and results out of the block.
// ----------------------------------------------------------------------------
interface pss_in_if;
    logic        valid;
    logic        ready;
    logic [5:0]  entry_index;
    logic        runnable;
    logic [6:0]  static_priority;
    logic [31:0] run_ticks;
    logic [31:0] sleep_ticks;
    logic [31:0] run_count;
    logic [31:0] start_tick;
    logic        last;

    modport source (
        output valid, entry_index, runnable, static_priority, run_ticks,
               sleep_ticks, run_count, start_tick, last,
        input  ready
    );

    modport sink (
        input  valid, entry_index, runnable, static_priority, run_ticks,
               sleep_ticks, run_count, start_tick, last,
        output ready
    );
endinterface

interface pss_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [5:0] winner_index;
    logic [6:0] winner_priority;

    modport source (
        output valid, found, winner_index, winner_priority,
        input  ready
    );

    modport sink (
        input  valid, found, winner_index, winner_priority,
        output ready
    );
endinterface

// ===== rtl/priority_scheduler_select_top.sv =====
// ----------------------------------------------------------------------------
// priority_scheduler_select_top
// Scans process table entries and picks the runnable one with the best
// dynamic priority.
// ----------------------------------------------------------------------------
// Each request is one table entry. A runnable entry gets niceness
// sleep*10/(run+sleep) (5 when both counts are zero) and dynamic priority
// static - niceness + 5 clamped to 0..100; the lowest value wins, ties go to
// fewer runs, then the earlier start tick, then the earlier entry. The entry
// flagged last closes the scan: one result (found, winner slot and priority)
// is sent and the selection starts over. Each entry passes through request
// intake, four steps of the restoring niceness divider, and a compare and
// update, during which the next request can already be taken. The result
// sits in an output register, so a stalled result only holds the block when
// the next scan ends before it is taken.
module priority_scheduler_select_top (
    input  logic      clk,
    input  logic      rst_n,
    pss_in_if.sink    in_ch,
    pss_out_if.source out_ch
);
    import pss_pkg::*;

    in_item_t    item;
    out_item_t   result;
    pss_cmd_t    cmd;
    pss_status_t status;
    logic        in_ready;
    logic        out_valid;

    assign item.entry_index     = in_ch.entry_index;
    assign item.runnable        = in_ch.runnable;
    assign item.static_priority = in_ch.static_priority;
    assign item.run_ticks       = in_ch.run_ticks;
    assign item.sleep_ticks     = in_ch.sleep_ticks;
    assign item.run_count       = in_ch.run_count;
    assign item.start_tick      = in_ch.start_tick;
    assign item.last            = in_ch.last;

    assign in_ch.ready            = in_ready;
    assign out_ch.valid           = out_valid;
    assign out_ch.found           = result.found;
    assign out_ch.winner_index    = result.winner_index;
    assign out_ch.winner_priority = result.winner_priority;

    pss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    pss_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

// ===== rtl/pss_ctrl.sv =====
// ----------------------------------------------------------------------------
// pss_ctrl
// Sequencer: request intake, divide steps, compare/update and result hand-off.
// ----------------------------------------------------------------------------
module pss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  pss_pkg::pss_status_t status,
    output pss_pkg::pss_cmd_t    cmd
);
    import pss_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              emit_ok;
    logic              accept;

    assign emit_ok   = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_UPD:  in_ready = !status.last || emit_ok;
            ST_EMIT: in_ready = emit_ok;
            default: in_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        cmd.load     = accept;
        cmd.div_step = (state_reg == ST_DIV);
        cmd.update   = (state_reg == ST_UPD);
        cmd.emit     = ((state_reg == ST_UPD) && status.last && emit_ok) ||
                       ((state_reg == ST_EMIT) && emit_ok);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (status.last && !emit_ok)
                    state_next = ST_EMIT;
                else if (accept)
                    state_next = ST_DIV;
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (emit_ok)
                    state_next = accept ? ST_DIV : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign step_next = (state_reg == ST_DIV) ? step_reg + STEP_W'(1) : '0;

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/pss_datapath.sv =====
// ----------------------------------------------------------------------------
// pss_datapath
// Niceness divider, dynamic priority, best-entry tracking and result register.
// ----------------------------------------------------------------------------
module pss_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pss_pkg::in_item_t    item,
    input  pss_pkg::pss_cmd_t    cmd,
    output pss_pkg::pss_status_t status,
    output pss_pkg::out_item_t   result
);
    import pss_pkg::*;

    // request registers
    logic [SLOT_W-1:0] slot_reg;
    logic              runnable_reg;
    logic [PRIO_W-1:0] stat_reg;
    logic [TICK_W-1:0] runs_reg;
    logic [TICK_W-1:0] start_reg;
    logic              last_reg;
    logic              zero_reg;

    // divider
    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [Q_W-1:0]    q_reg;
    logic [SUM_W-1:0]  total;
    logic [NUM_W-1:0]  sleep_ext;
    logic [NUM_W-1:0]  product;
    logic              ge;

    // best entry
    logic              best_valid_reg;
    logic [SLOT_W-1:0] best_slot_reg;
    logic [PRIO_W-1:0] best_prio_reg;
    logic [TICK_W-1:0] best_runs_reg;
    logic [TICK_W-1:0] best_start_reg;
    logic              best_valid_next;
    logic [SLOT_W-1:0] best_slot_next;
    logic [PRIO_W-1:0] best_prio_next;
    logic [TICK_W-1:0] best_runs_next;
    logic [TICK_W-1:0] best_start_next;

    logic [Q_W-1:0]    nice;
    logic [PRIO_W:0]   base;
    logic [PRIO_W:0]   diff;
    logic [PRIO_W-1:0] dyn_prio;
    logic              take;

    out_item_t         result_reg;

    assign status.last = last_reg;
    assign result      = result_reg;

    assign total     = {1'b0, item.run_ticks} + {1'b0, item.sleep_ticks};
    assign sleep_ext = {4'b0, item.sleep_ticks};
    assign product   = (sleep_ext << 3) + (sleep_ext << 1);
    assign ge        = (rem_reg >= dsh_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            slot_reg     <= item.entry_index;
            runnable_reg <= item.runnable;
            stat_reg     <= item.static_priority;
            runs_reg     <= item.run_count;
            start_reg    <= item.start_tick;
            zero_reg     <= (total == '0);
            rem_reg      <= product;
            dsh_reg      <= {total, 3'b000};
            q_reg        <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? rem_reg - dsh_reg : rem_reg;
            q_reg   <= {q_reg[Q_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_reg <= 1'b0;
        else if (cmd.load)
            last_reg <= item.last;
    end

    // dynamic priority: static - niceness + 5, clamped to 0..100
    assign nice = zero_reg ? NICE_IDLE : q_reg;
    assign base = {1'b0, stat_reg} + PRIO_BIAS;
    assign diff = base - {{(PRIO_W + 1 - Q_W){1'b0}}, nice};

    always_comb
    begin
        if (base < {{(PRIO_W + 1 - Q_W){1'b0}}, nice})
            dyn_prio = '0;
        else if (diff > {1'b0, PRIO_MAX})
            dyn_prio = PRIO_MAX;
        else
            dyn_prio = diff[PRIO_W-1:0];
    end

    always_comb
    begin
        if (!best_valid_reg)
            take = 1'b1;
        else if (dyn_prio < best_prio_reg)
            take = 1'b1;
        else if (dyn_prio == best_prio_reg)
            take = (runs_reg < best_runs_reg) ||
                   ((runs_reg == best_runs_reg) && (start_reg < best_start_reg));
        else
            take = 1'b0;
    end

    always_comb
    begin
        best_valid_next = best_valid_reg;
        best_slot_next  = best_slot_reg;
        best_prio_next  = best_prio_reg;
        best_runs_next  = best_runs_reg;
        best_start_next = best_start_reg;
        if (cmd.update && runnable_reg && take)
        begin
            best_valid_next = 1'b1;
            best_slot_next  = slot_reg;
            best_prio_next  = dyn_prio;
            best_runs_next  = runs_reg;
            best_start_next = start_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg <= 1'b0;
            best_slot_reg  <= '0;
            best_prio_reg  <= '0;
            best_runs_reg  <= '0;
            best_start_reg <= '0;
        end
        else if (cmd.emit)
        begin
            best_valid_reg <= 1'b0;
            best_slot_reg  <= '0;
            best_prio_reg  <= '0;
            best_runs_reg  <= '0;
            best_start_reg <= '0;
        end
        else
        begin
            best_valid_reg <= best_valid_next;
            best_slot_reg  <= best_slot_next;
            best_prio_reg  <= best_prio_next;
            best_runs_reg  <= best_runs_next;
            best_start_reg <= best_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.found           <= best_valid_next;
            result_reg.winner_index    <= best_valid_next ? best_slot_next : '0;
            result_reg.winner_priority <= best_valid_next ? best_prio_next : '0;
        end
    end

endmodule

// ===== dv/pss_winner_checker.sv =====
// ----------------------------------------------------------------------------
// pss_winner_checker
// Watches the request and result channels of the scheduler select block,
// folds each accepted table entry into its own running selection and checks
// every result against the winner it predicted for that scan.
// ----------------------------------------------------------------------------
module pss_winner_checker (
    input  logic clk,
    input  logic rst_n,
    pss_in_if    req_ch,
    pss_out_if   res_ch,
    output int   mismatches,
    output int   results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import pss_pkg::*;

    logic              best_valid = 1'b0;
    logic [SLOT_W-1:0] best_slot  = '0;
    logic [PRIO_W-1:0] best_prio  = '0;
    logic [TICK_W-1:0] best_runs  = '0;
    logic [TICK_W-1:0] best_start = '0;

    out_item_t winners_due[$];

    function automatic logic [PRIO_W-1:0] predict_priority(
        logic [PRIO_W-1:0] stat,
        logic [TICK_W-1:0] run,
        logic [TICK_W-1:0] sleep
    );
        logic [SUM_W-1:0] total;
        logic [NUM_W-1:0] scaled;
        int               nice;
        int               dp;
        total  = SUM_W'(run) + SUM_W'(sleep);
        scaled = NUM_W'(sleep) * NUM_W'(10);
        nice   = 5;
        if (total != '0)
            nice = int'(scaled / NUM_W'(total));
        dp = int'(stat) - nice + 5;
        if (dp < 0)
            dp = 0;
        if (dp > 100)
            dp = 100;
        return PRIO_W'(dp);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t ns mismatch: %s got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic fold_entry();
        logic [PRIO_W-1:0] dp;
        bit                take;
        out_item_t         win;
        if (req_ch.runnable)
        begin
            dp = predict_priority(req_ch.static_priority, req_ch.run_ticks,
                                  req_ch.sleep_ticks);
            if (!best_valid)
                take = 1'b1;
            else if (dp < best_prio)
                take = 1'b1;
            else if (dp == best_prio)
                take = (req_ch.run_count < best_runs) ||
                       (req_ch.run_count == best_runs && req_ch.start_tick < best_start);
            else
                take = 1'b0;
            if (take)
            begin
                best_valid = 1'b1;
                best_slot  = req_ch.entry_index;
                best_prio  = dp;
                best_runs  = req_ch.run_count;
                best_start = req_ch.start_tick;
            end
        end
        if (req_ch.last)
        begin
            win.found           = best_valid;
            win.winner_index    = best_valid ? best_slot : '0;
            win.winner_priority = best_valid ? best_prio : '0;
            winners_due.push_back(win);
            best_valid = 1'b0;
            best_slot  = '0;
            best_prio  = '0;
            best_runs  = '0;
            best_start = '0;
        end
    endtask

    task automatic check_result();
        out_item_t want;
        if (winners_due.size() == 0)
        begin
            report_mismatch("unexpected result, winner_index", res_ch.winner_index, 0);
            return;
        end
        want = winners_due.pop_front();
        if (res_ch.found !== want.found)
            report_mismatch("found", res_ch.found, want.found);
        if (res_ch.winner_index !== want.winner_index)
            report_mismatch("winner_index", res_ch.winner_index, want.winner_index);
        if (res_ch.winner_priority !== want.winner_priority)
            report_mismatch("winner_priority", res_ch.winner_priority, want.winner_priority);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            fold_entry();
        if (rst_n && res_ch.valid && res_ch.ready)
            check_result();
        results_due = winners_due.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives table scans into the scheduler select block: a directed set of
// corner cases, then random scans under several idle and stall patterns,
// including one long result hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pss_pkg::*;

    localparam int ITEMS_PER_PHASE = 320;
    localparam int HOLD_CYCLES     = 400;
    localparam int TAIL_CYCLES     = 30;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_req;
    int   hold_left;
    int   mismatches;
    int   results_due;

    pss_in_if  req_ch ();
    pss_out_if res_ch ();

    priority_scheduler_select_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_ch),
        .out_ch (res_ch)
    );

    pss_winner_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_ch      (req_ch),
        .res_ch      (res_ch),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [TICK_W-1:0] rand_tick();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2, 3: return $urandom;
            default: return $urandom_range(20);
        endcase
    endfunction

    function automatic in_item_t make_entry(
        int slot, bit runnable, int stat,
        logic [TICK_W-1:0] run, logic [TICK_W-1:0] sleep,
        logic [TICK_W-1:0] runs, logic [TICK_W-1:0] start, bit last
    );
        in_item_t e;
        e.entry_index     = SLOT_W'(slot);
        e.runnable        = runnable;
        e.static_priority = PRIO_W'(stat);
        e.run_ticks       = run;
        e.sleep_ticks     = sleep;
        e.run_count       = runs;
        e.start_tick      = start;
        e.last            = last;
        return e;
    endfunction

    function automatic in_item_t random_entry(bit last);
        in_item_t e;
        e.entry_index = SLOT_W'($urandom_range(63));
        e.runnable    = ($urandom_range(99) < 75);
        case ($urandom_range(9))
            0: e.static_priority = '0;
            1: e.static_priority = '1;
            2: e.static_priority = PRIO_W'($urandom_range(101, 127));
            3: e.static_priority = PRIO_W'($urandom);
            default: e.static_priority = PRIO_W'($urandom_range(45, 55));
        endcase
        e.run_ticks   = rand_tick();
        e.sleep_ticks = rand_tick();
        e.run_count   = ($urandom_range(3) == 0) ? rand_tick() : TICK_W'($urandom_range(3));
        e.start_tick  = ($urandom_range(3) == 0) ? rand_tick() : TICK_W'($urandom_range(3));
        e.last        = last;
        return e;
    endfunction

    task automatic offer_entry(in_item_t e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.entry_index     <= e.entry_index;
        req_ch.runnable        <= e.runnable;
        req_ch.static_priority <= e.static_priority;
        req_ch.run_ticks       <= e.run_ticks;
        req_ch.sleep_ticks     <= e.sleep_ticks;
        req_ch.run_count       <= e.run_count;
        req_ch.start_tick      <= e.start_tick;
        req_ch.last            <= e.last;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        res_ch.ready = 1'b0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int sent;
        int len;
        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.entry_index     = '0;
        req_ch.runnable        = 1'b0;
        req_ch.static_priority = '0;
        req_ch.run_ticks       = '0;
        req_ch.sleep_ticks     = '0;
        req_ch.run_count       = '0;
        req_ch.start_tick      = '0;
        req_ch.last            = 1'b0;
        send_idle_pct          = 0;
        recv_stall_pct         = 0;
        hold_req               = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // scans with nothing runnable
        offer_entry(make_entry(0, 0, 0, 0, 0, 0, 0, 1));
        offer_entry(make_entry(5, 0, 20, 3, 4, 1, 1, 0));
        offer_entry(make_entry(6, 0, 10, 0, 0, 0, 0, 1));
        // clamps at both ends, non-runnable last entry
        offer_entry(make_entry(0, 1, 0, 0, 32'hFFFF_FFFF, 7, 9, 0));
        offer_entry(make_entry(63, 1, 127, 32'hFFFF_FFFF, 0, 0, 0, 0));
        offer_entry(make_entry(1, 1, 100, 0, 0, 0, 0, 0));
        offer_entry(make_entry(2, 0, 0, 0, 0, 0, 0, 1));
        // tie breaks on runs, start tick, then full tie keeps the earlier
        offer_entry(make_entry(10, 1, 50, 0, 0, 5, 100, 0));
        offer_entry(make_entry(11, 1, 50, 0, 0, 3, 200, 0));
        offer_entry(make_entry(12, 1, 50, 1, 1, 3, 150, 0));
        offer_entry(make_entry(13, 1, 50, 0, 0, 3, 150, 0));
        offer_entry(make_entry(14, 1, 50, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
        offer_entry(make_entry(15, 1, 51, 0, 0, 0, 0, 1));
        // single entry, every field at its top
        offer_entry(make_entry(63, 1, 127, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
        // later entries improve but for slot 22, last one clamps to zero
        offer_entry(make_entry(20, 1, 30, 10, 0, 0, 0, 0));
        offer_entry(make_entry(21, 1, 30, 3, 7, 0, 0, 0));
        offer_entry(make_entry(22, 1, 30, 1, 2, 0, 0, 0));
        offer_entry(make_entry(23, 1, 2, 0, 100, 0, 0, 1));

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_req = 1'b1; end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                case ($urandom_range(39))
                    0: len = $urandom_range(60, 70);
                    1, 2, 3, 4, 5: len = $urandom_range(7, 20);
                    default: len = $urandom_range(1, 6);
                endcase
                for (int k = 0; k < len; k++)
                    offer_entry(random_entry(k == len - 1));
                sent += len;
            end
        end
        req_ch.valid <= 1'b0;

        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
